>>> design/srrw_pkg.sv
// Shared types and constants of the selective repeat receive window.
`timescale 1ns / 1ps
`default_nettype none

package srrw_pkg;

   localparam int unsigned SLOTS_DEFAULT = 32;
   localparam int unsigned MAX_RESULTS   = 32;
   localparam logic [4:0]  WINDOW_RESET  = 5'd31;

   localparam logic [1:0] KIND_DELIVER = 2'd0;
   localparam logic [1:0] KIND_NACK    = 2'd1;
   localparam logic [1:0] KIND_RESEND  = 2'd2;
   localparam logic [1:0] KIND_EOS     = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_TRUNC = 2'd1;

   typedef struct packed {
      logic [7:0]  seq_number;
      logic [9:0]  payload_length;
      logic        is_data;
      logic [1:0]  decode_status;
      logic [31:0] time_stamp;
      logic [9:0]  payload_handle;
   } pkt_type;

   typedef struct packed {
      logic [9:0]  length;
      logic [31:0] stamp;
      logic [9:0]  handle;
   } slot_type;

   typedef struct packed {
      logic        nack;
      logic [7:0]  seq;
      logic [4:0]  window;
      logic [31:0] stamp;
   } ack_type;

   typedef struct packed {
      logic [1:0] kind;
      ack_type    ack;
      logic [9:0] handle;
      logic [9:0] length;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

>>> design/srrw_slot_ram.sv
// Reorder slot memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module srrw_slot_ram #(
   parameter int unsigned REORDER_SLOTS = srrw_pkg::SLOTS_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 wr_en,
   input  wire  [$clog2(REORDER_SLOTS)-1:0]    wr_idx,
   input  srrw_pkg::slot_type                  wr_data,
   input  wire                                 rd_en,
   input  wire  [$clog2(REORDER_SLOTS)-1:0]    rd_idx,
   output srrw_pkg::slot_type                  rd_data
);
   import srrw_pkg::*;

   slot_type slot_mem [REORDER_SLOTS];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/srrw_ctrl.sv
// Window sequencer: window test, slot valid bits, in-order drain, acknowledgment state.
`timescale 1ns / 1ps
`default_nettype none

module srrw_ctrl #(
   parameter int unsigned REORDER_SLOTS = srrw_pkg::SLOTS_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_write_enable,
   input  wire  [4:0]           csr_write_data,
   input  wire                  pkt_accept,
   input  srrw_pkg::pkt_type    pkt,
   output logic                 pkt_ready,
   input  wire                  res_free,
   output logic                 res_valid,
   output srrw_pkg::result_type res
);
   import srrw_pkg::*;

   localparam int unsigned IDX_W = $clog2(REORDER_SLOTS);
   localparam int unsigned CNT_W = $clog2(MAX_RESULTS);
   localparam logic [IDX_W:0]   SLOTS_EXT  = (IDX_W+1)'(REORDER_SLOTS);
   localparam logic [IDX_W-1:0] SLOTS_LAST = IDX_W'(REORDER_SLOTS - 1);
   localparam logic [8:0]       SLOTS_W9   = 9'(REORDER_SLOTS);
   localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(MAX_RESULTS - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EVAL = 4'b0010,
      ST_READ = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [7:0]             exp_seq_ff, exp_seq_in;
   logic [IDX_W-1:0]       exp_idx_ff, exp_idx_in;
   logic [4:0]             window_ff, window_in;
   logic [4:0]             max_window_ff;
   logic [REORDER_SLOTS-1:0] valid_ff, valid_in;
   ack_type                saved_ff, saved_in;
   logic                   saved_valid_ff, saved_valid_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic [7:0]       seq_offset;
   logic             in_window;
   logic [IDX_W:0]   slot_sum;
   logic [IDX_W:0]   slot_wrap;
   logic [IDX_W-1:0] slot_idx;
   logic [IDX_W-1:0] next_idx;
   logic [5:0]       half_sum;
   logic [4:0]       grown_window;
   logic             drain_last;
   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_idx;
   slot_type         ram_rd_data;
   slot_type         ram_wr_data;
   ack_type          ack_new;

   srrw_slot_ram #(
      .REORDER_SLOTS(REORDER_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_idx  (slot_idx),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_idx  (ram_rd_idx),
      .rd_data (ram_rd_data)
   );

   // Slot of the packet: past the 8-bit wrap the sequence number is already below the slot count.
   assign seq_offset = pkt.seq_number - exp_seq_ff;
   assign in_window  = (seq_offset < {3'b000, window_ff}) && ({1'b0, seq_offset} < SLOTS_W9);
   assign slot_sum   = {1'b0, exp_idx_ff} + {1'b0, seq_offset[IDX_W-1:0]};
   assign slot_wrap  = (slot_sum >= SLOTS_EXT) ? (slot_sum - SLOTS_EXT) : slot_sum;
   assign slot_idx   = (pkt.seq_number < exp_seq_ff) ? pkt.seq_number[IDX_W-1:0]
                                                     : slot_wrap[IDX_W-1:0];
   assign next_idx   = ((exp_seq_ff == 8'hFF) || (exp_idx_ff == SLOTS_LAST)) ? '0
                                                     : exp_idx_ff + 1'b1;

   assign half_sum     = {1'b0, window_ff} + 6'd1;
   assign grown_window = (window_ff < max_window_ff) ? half_sum[4:0] : window_ff;
   // the slot just drained is never next, even when the wrap lands back on it
   assign drain_last   = (count_ff == CNT_LAST) || !valid_ff[next_idx]
                         || (next_idx == exp_idx_ff);
   assign ram_wr_data  = '{length: pkt.payload_length, stamp: pkt.time_stamp,
                           handle: pkt.payload_handle};
   assign ack_new      = '{nack: 1'b0, seq: exp_seq_ff + 8'd1, window: grown_window,
                           stamp: ram_rd_data.stamp};
   assign pkt_ready    = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      exp_seq_in     = exp_seq_ff;
      exp_idx_in     = exp_idx_ff;
      window_in      = window_ff;
      valid_in       = valid_ff;
      saved_in       = saved_ff;
      saved_valid_in = saved_valid_ff;
      done_in        = done_ff;
      count_in       = count_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      ram_rd_idx     = exp_idx_ff;
      res_valid      = 1'b0;
      res            = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (pkt_accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_IDLE;
            if (done_ff) begin
               state_in = ST_IDLE;
            end else if (pkt.decode_status == STATUS_OK) begin
               if (in_window) begin
                  ram_wr_en          = 1'b1;
                  valid_in[slot_idx] = 1'b1;
                  count_in           = '0;
                  if (valid_ff[exp_idx_ff] || (slot_idx == exp_idx_ff)) begin
                     state_in = ST_READ;
                  end
               end else if (saved_valid_ff) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_RESEND;
                  res.ack   = saved_ff;
                  res.last  = 1'b1;
                  if (!res_free) begin
                     state_in = ST_EVAL;
                  end
               end
            end else if ((pkt.decode_status == STATUS_TRUNC) && pkt.is_data) begin
               res_valid = 1'b1;
               res.kind  = KIND_NACK;
               res.ack   = '{nack: 1'b1, seq: pkt.seq_number, window: half_sum[5:1],
                             stamp: pkt.time_stamp};
               res.last  = 1'b1;
               if (res_free) begin
                  window_in      = half_sum[5:1];
                  saved_in       = res.ack;
                  saved_valid_in = 1'b1;
               end else begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            res_valid = 1'b1;
            if (ram_rd_data.length == 10'd0) begin
               res.kind       = KIND_EOS;
               res.ack.window = window_ff;
               res.last       = 1'b1;
               if (res_free) begin
                  valid_in[exp_idx_ff] = 1'b0;
                  done_in              = 1'b1;
                  state_in             = ST_IDLE;
               end
            end else begin
               res.kind   = KIND_DELIVER;
               res.ack    = ack_new;
               res.handle = ram_rd_data.handle;
               res.length = ram_rd_data.length;
               res.last   = drain_last;
               if (res_free) begin
                  valid_in[exp_idx_ff] = 1'b0;
                  window_in            = grown_window;
                  saved_in             = ack_new;
                  saved_valid_in       = 1'b1;
                  exp_seq_in           = exp_seq_ff + 8'd1;
                  exp_idx_in           = next_idx;
                  count_in             = count_ff + 1'b1;
                  if (drain_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     // fetch the next slot while this beat leaves
                     ram_rd_en  = 1'b1;
                     ram_rd_idx = next_idx;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         exp_seq_ff     <= '0;
         exp_idx_ff     <= '0;
         window_ff      <= WINDOW_RESET;
         max_window_ff  <= WINDOW_RESET;
         valid_ff       <= '0;
         saved_ff       <= '0;
         saved_valid_ff <= 1'b0;
         done_ff        <= 1'b0;
         count_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         exp_seq_ff     <= exp_seq_in;
         exp_idx_ff     <= exp_idx_in;
         window_ff      <= window_in;
         valid_ff       <= valid_in;
         saved_ff       <= saved_in;
         saved_valid_ff <= saved_valid_in;
         done_ff        <= done_in;
         count_ff       <= count_in;
         if (csr_write_enable) begin
            max_window_ff <= csr_write_data;
         end
      end
   end

endmodule

`default_nettype wire

>>> design/selective_repeat_receive_window.sv
// Top level of the selective repeat receive window: header capture and result register.
`timescale 1ns / 1ps
`default_nettype none

// Selective repeat receive window.
// req_*: one decoded packet header per beat (valid/ready). req_ready is high
//   only while no header is being worked on; one header is handled at a time.
// rsp_*: result beats (valid/ready) from a single output register; rsp_last
//   marks the final beat caused by a header. Headers that cause nothing give
//   no beat.
// csr_write_enable/csr_write_data: max_window; the user must write it only while the
//   block idles, and the block itself does not enforce this.
// A resend or NACK beat is worked out in the evaluate state and registered in the
//   output register. A delivering header passes the evaluate, read and emit states
//   to its first beat, then gives one beat per cycle while rsp_ready stays high,
//   each slot read ahead from the slot memory, up to 32 beats.
// A stalled rsp_ready holds the current beat and freezes the drain; the
//   header captured stays put until its last beat enters the output register.
// Reset sets window and max_window to 31, clears expected number, slot valid bits
//   and saved acknowledgment at once; slot contents stay and no sweep runs.
module selective_repeat_receive_window #(
   parameter int unsigned REORDER_SLOTS = srrw_pkg::SLOTS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_seq_number,
   input  wire  [9:0]  req_payload_length,
   input  wire         req_is_data,
   input  wire  [1:0]  req_decode_status,
   input  wire  [31:0] req_time_stamp,
   input  wire  [9:0]  req_payload_handle,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic        rsp_ack_is_nack,
   output logic [7:0]  rsp_ack_seq,
   output logic [4:0]  rsp_ack_window,
   output logic [31:0] rsp_ack_stamp,
   output logic [9:0]  rsp_deliver_handle,
   output logic [9:0]  rsp_deliver_length,
   output logic        rsp_last,
   input  wire         csr_write_enable,
   input  wire  [4:0]  csr_write_data
);
   import srrw_pkg::*;

   pkt_type    pkt_ff;
   result_type res;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       res_valid;
   logic       res_free;
   logic       pkt_accept;

   assign pkt_accept = req_valid && req_ready;
   assign res_free   = !rsp_valid_ff || rsp_ready;

   srrw_ctrl #(
      .REORDER_SLOTS(REORDER_SLOTS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pkt_accept       (pkt_accept),
      .pkt              (pkt_ff),
      .pkt_ready        (req_ready),
      .res_free         (res_free),
      .res_valid        (res_valid),
      .res              (res)
   );

   always_ff @(posedge clock) begin
      if (pkt_accept) begin
         pkt_ff <= '{seq_number: req_seq_number, payload_length: req_payload_length,
                     is_data: req_is_data, decode_status: req_decode_status,
                     time_stamp: req_time_stamp, payload_handle: req_payload_handle};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_free) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_free && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_ack_is_nack    = rsp_ff.ack.nack;
   assign rsp_ack_seq        = rsp_ff.ack.seq;
   assign rsp_ack_window     = rsp_ff.ack.window;
   assign rsp_ack_stamp      = rsp_ff.ack.stamp;
   assign rsp_deliver_handle = rsp_ff.handle;
   assign rsp_deliver_length = rsp_ff.length;
   assign rsp_last           = rsp_ff.last;

endmodule

`default_nettype wire

>>> design/srrw_checker.sv
// Port checker for the selective repeat receive window, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module srrw_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [1:0]  rsp_kind,
   input wire        rsp_ack_is_nack,
   input wire [31:0] rsp_ack_stamp,
   input wire [9:0]  rsp_deliver_handle,
   input wire [9:0]  rsp_deliver_length,
   input wire        rsp_last
);
   import srrw_pkg::*;

   // a stalled beat holds its kind, stamp, handle and last flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_ack_stamp)
         && $stable(rsp_deliver_handle) && $stable(rsp_last))
      else $error("stalled result beat changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_DELIVER) |->
         (rsp_deliver_handle == 10'd0) && (rsp_deliver_length == 10'd0))
      else $error("deliver fields set on a non-deliver beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_NACK || rsp_kind == KIND_RESEND || rsp_kind == KIND_EOS)
         |-> rsp_last)
      else $error("single-beat result not marked last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DELIVER || rsp_kind == KIND_EOS) |-> !rsp_ack_is_nack)
      else $error("NACK flag on a delivering beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DELIVER) |-> (rsp_deliver_length != 10'd0))
      else $error("deliver beat with zero length");

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_kind           (rsp_kind),
   .rsp_ack_is_nack    (rsp_ack_is_nack),
   .rsp_ack_stamp      (rsp_ack_stamp),
   .rsp_deliver_handle (rsp_deliver_handle),
   .rsp_deliver_length (rsp_deliver_length),
   .rsp_last           (rsp_last)
);

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the selective repeat receive window.
`timescale 1ns / 1ps

module tb;
   import srrw_pkg::*;

   localparam int unsigned SLOTS = SLOTS_DEFAULT;
   localparam logic [1:0] STATUS_BAD    = 2'd2;
   localparam logic [1:0] STATUS_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 40;     // time to the first beat plus a full drain
   localparam int HOLD_OFF     = 150;
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   pkt_type     req_pkt = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic        rsp_ack_is_nack;
   logic [7:0]  rsp_ack_seq;
   logic [4:0]  rsp_ack_window;
   logic [31:0] rsp_ack_stamp;
   logic [9:0]  rsp_deliver_handle;
   logic [9:0]  rsp_deliver_length;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [4:0]  csr_write_data = 5'd0;

   // receiver state as the block should hold it
   logic [7:0] next_seq = 8'd0;
   logic [4:0] cur_window = WINDOW_RESET;
   logic [4:0] max_window_cfg = WINDOW_RESET;
   bit         slot_full [SLOTS];
   slot_type   slot_mem [SLOTS];
   ack_type    last_ack = '0;
   bit         last_ack_ok = 1'b0;
   bit         stream_ended = 1'b0;

   pkt_type    pending_q [$];
   result_type due_results [$];
   int         items_queued = 0;
   int         error_count = 0;
   int         beats_seen = 0;
   int         send_gap = 0;
   int         ready_hold = 0;
   int         quiet_cycles = 0;
   bit         no_idle = 1'b0;
   bit         held_off = 1'b0;

   selective_repeat_receive_window #(.REORDER_SLOTS(SLOTS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_seq_number     (req_pkt.seq_number),
      .req_payload_length (req_pkt.payload_length),
      .req_is_data        (req_pkt.is_data),
      .req_decode_status  (req_pkt.decode_status),
      .req_time_stamp     (req_pkt.time_stamp),
      .req_payload_handle (req_pkt.payload_handle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_ack_is_nack    (rsp_ack_is_nack),
      .rsp_ack_seq        (rsp_ack_seq),
      .rsp_ack_window     (rsp_ack_window),
      .rsp_ack_stamp      (rsp_ack_stamp),
      .rsp_deliver_handle (rsp_deliver_handle),
      .rsp_deliver_length (rsp_deliver_length),
      .rsp_last           (rsp_last),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic pkt_type pkt(input logic [7:0] seq, input int len, input bit is_data,
                                   input logic [1:0] status, input logic [31:0] stamp,
                                   input int handle);
      pkt_type p;
      p.seq_number     = seq;
      p.payload_length = 10'(len);
      p.is_data        = is_data;
      p.decode_status  = status;
      p.time_stamp     = stamp;
      p.payload_handle = 10'(handle);
      return p;
   endfunction

   task automatic offer(input pkt_type p);
      pending_q.push_back(p);
      items_queued++;
   endtask

   task automatic flag_error(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("ERROR beat %0d: %s got 0x%0h want 0x%0h", beats_seen, what, got, want);
      error_count++;
   endtask

   // Work out the beats one header causes and queue them, last flag on the final one.
   task automatic predict_packet(input pkt_type p);
      logic [7:0] seq_offset;
      int         idx;
      int         count;
      bit         draining;
      slot_type   ent;
      result_type r;
      result_type fresh [$];
      if (!stream_ended) begin
         if (p.decode_status == STATUS_OK) begin
            seq_offset = p.seq_number - next_seq;
            if (seq_offset < cur_window && seq_offset < SLOTS) begin
               idx = p.seq_number % SLOTS;
               slot_mem[idx].length = p.payload_length;
               slot_mem[idx].stamp  = p.time_stamp;
               slot_mem[idx].handle = p.payload_handle;
               slot_full[idx] = 1'b1;
               count = 0;
               draining = 1'b1;
               while (draining) begin
                  idx = next_seq % SLOTS;
                  if (!slot_full[idx]) begin
                     draining = 1'b0;
                  end else begin
                     ent = slot_mem[idx];
                     slot_full[idx] = 1'b0;
                     r = '0;
                     if (ent.length == 10'd0) begin
                        r.kind = KIND_EOS;
                        r.ack.window = cur_window;
                        stream_ended = 1'b1;
                        draining = 1'b0;
                     end else begin
                        if (cur_window < max_window_cfg) cur_window = cur_window + 5'd1;
                        last_ack.nack   = 1'b0;
                        last_ack.seq    = next_seq + 8'd1;
                        last_ack.window = cur_window;
                        last_ack.stamp  = ent.stamp;
                        last_ack_ok = 1'b1;
                        r.kind   = KIND_DELIVER;
                        r.ack    = last_ack;
                        r.handle = ent.handle;
                        r.length = ent.length;
                        next_seq = next_seq + 8'd1;
                     end
                     fresh.push_back(r);
                     count++;
                     if (count == MAX_RESULTS) draining = 1'b0;
                  end
               end
            end else if (last_ack_ok) begin
               r = '0;
               r.kind = KIND_RESEND;
               r.ack  = last_ack;
               fresh.push_back(r);
            end
         end else if (p.decode_status == STATUS_TRUNC && p.is_data) begin
            cur_window = 5'((int'(cur_window) + 1) / 2);
            last_ack.nack   = 1'b1;
            last_ack.seq    = p.seq_number;
            last_ack.window = cur_window;
            last_ack.stamp  = p.time_stamp;
            last_ack_ok = 1'b1;
            r = '0;
            r.kind = KIND_NACK;
            r.ack  = last_ack;
            fresh.push_back(r);
         end
      end
      if (fresh.size() != 0) begin
         r = fresh.pop_back();
         r.last = 1'b1;
         fresh.push_back(r);
         foreach (fresh[k]) due_results.push_back(fresh[k]);
      end
   endtask

   task automatic check_beat();
      result_type want;
      if (due_results.size() == 0) begin
         flag_error("beat with nothing due, kind", 32'(rsp_kind), 32'd0);
      end else begin
         want = due_results.pop_front();
         if (rsp_kind !== want.kind) flag_error("kind", 32'(rsp_kind), 32'(want.kind));
         if (rsp_ack_is_nack !== want.ack.nack)
            flag_error("ack_is_nack", 32'(rsp_ack_is_nack), 32'(want.ack.nack));
         if (rsp_ack_seq !== want.ack.seq)
            flag_error("ack_seq", 32'(rsp_ack_seq), 32'(want.ack.seq));
         if (rsp_ack_window !== want.ack.window)
            flag_error("ack_window", 32'(rsp_ack_window), 32'(want.ack.window));
         if (rsp_ack_stamp !== want.ack.stamp)
            flag_error("ack_stamp", rsp_ack_stamp, want.ack.stamp);
         if (rsp_deliver_handle !== want.handle)
            flag_error("deliver_handle", 32'(rsp_deliver_handle), 32'(want.handle));
         if (rsp_deliver_length !== want.length)
            flag_error("deliver_length", 32'(rsp_deliver_length), 32'(want.length));
         if (rsp_last !== want.last) flag_error("last", 32'(rsp_last), 32'(want.last));
      end
   endtask

   // Sender: hold each header until taken, then idle for the drawn gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready) predict_packet(req_pkt);
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (pending_q.size() != 0) begin
               req_pkt <= pending_q.pop_front();
               req_valid <= 1'b1;
               send_gap <= no_idle ? 0 : $urandom_range(0, 6);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each beat, then hold off for the drawn number of cycles.
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold <= 0;
      end else if (rsp_valid && rsp_ready) begin
         check_beat();
         beats_seen++;
         stall = no_idle ? 0 : $urandom_range(0, 6);
         // one long hold-off so the block backs up onto its input
         if (!held_off && beats_seen == 80) begin
            stall = HOLD_OFF;
            held_off = 1'b1;
         end
         rsp_ready <= (stall == 0);
         ready_hold <= stall;
      end else if (ready_hold != 0) begin
         rsp_ready <= (ready_hold == 1);
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("timeout after %0d cycles without a beat", STALL_LIMIT);
         $display("selective_repeat_receive_window verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_max_window(input logic [4:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      max_window_cfg = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_sent();
      while (pending_q.size() != 0 || req_valid) @(negedge clock);
   endtask

   task automatic settle();
      wait_sent();
      while (due_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Noise headers that store nothing: outside any window during one burst, bad status, or truncated.
   task automatic queue_noise(input logic [7:0] base);
      case ($urandom_range(0, 4))
         0: offer(pkt(8'(int'(base) + 128 + $urandom_range(0, 64)), $urandom_range(0, 512),
                      1'($urandom), STATUS_OK, $urandom, $urandom_range(0, 1023)));
         1: offer(pkt(8'($urandom), $urandom_range(0, 512), 1'($urandom), STATUS_BAD,
                      $urandom, $urandom_range(0, 1023)));
         2: offer(pkt(8'($urandom), $urandom_range(0, 512), 1'($urandom), STATUS_UNUSED,
                      $urandom, $urandom_range(0, 1023)));
         3: offer(pkt(8'($urandom), $urandom_range(0, 512), 1'b0, STATUS_TRUNC,
                      $urandom, $urandom_range(0, 1023)));
         default: offer(pkt(8'($urandom), $urandom_range(0, 512), 1'b1, STATUS_TRUNC,
                            $urandom, $urandom_range(0, 1023)));
      endcase
   endtask

   // A run of consecutive numbers from the next expected one, shuffled.
   task automatic queue_burst();
      logic [7:0] base;
      int span, j, tmp, s;
      int order [32];
      base = next_seq;
      span = ($urandom_range(0, 3) == 0) ? int'(cur_window) : $urandom_range(1, cur_window);
      for (int k = 0; k < span; k++) order[k] = k;
      for (int k = span - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         tmp = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      // hold back the head so the whole run drains from one header
      if ($urandom_range(0, 3) == 0)
         for (int k = 0; k < span - 1; k++)
            if (order[k] == 0) begin
               order[k] = order[span - 1];
               order[span - 1] = 0;
            end
      // zero-length copy overwritten before the drain can reach it
      if (span >= 2 && $urandom_range(0, 3) == 0) begin
         s = $urandom_range(1, span - 1);
         offer(pkt(8'(int'(base) + s), 0, 1'b1, STATUS_OK, $urandom, $urandom_range(0, 1023)));
         offer(pkt(8'(int'(base) + s), $urandom_range(1, 512), 1'b1, STATUS_OK, $urandom,
                   $urandom_range(0, 1023)));
      end
      for (int k = 0; k < span; k++) begin
         if ($urandom_range(0, 7) == 0) queue_noise(base);
         if ($urandom_range(0, 15) == 0) begin
            offer(pkt(8'(int'(base) + order[k]), $urandom_range(0, 512), 1'b1, STATUS_TRUNC,
                      $urandom, $urandom_range(0, 1023)));
         end else begin
            offer(pkt(8'(int'(base) + order[k]), $urandom_range(1, 512),
                      $urandom_range(0, 3) != 0, STATUS_OK, $urandom, $urandom_range(0, 1023)));
            if ($urandom_range(0, 9) == 0)
               offer(pkt(8'(int'(base) + order[k]), $urandom_range(1, 512), 1'b1, STATUS_OK,
                         $urandom, $urandom_range(0, 1023)));
         end
      end
   endtask

   initial begin
      logic [4:0] window_plan [6];
      logic [7:0] e;
      int         phase_end;
      window_plan = '{5'd31, 5'd1, 5'd9, 5'd31, 5'd2, 5'd20};
      foreach (slot_full[k]) slot_full[k] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      set_max_window(5'd31);

      offer(pkt(8'd100, 10, 1'b1, STATUS_OK, 32'h1234_5678, 1));     // no ack saved yet
      offer(pkt(8'd5, 20, 1'b0, STATUS_TRUNC, 32'h0000_0005, 5));     // truncated non-data
      offer(pkt(8'd5, 20, 1'b1, STATUS_BAD, 32'h0000_0006, 6));
      offer(pkt(8'd5, 20, 1'b1, STATUS_UNUSED, 32'h0000_0007, 7));
      offer(pkt(8'd0, 512, 1'b0, STATUS_OK, 32'hFFFF_FFFF, 1023));    // non-data taken as data
      offer(pkt(8'd3, 1, 1'b1, STATUS_OK, 32'h0000_0000, 0));
      offer(pkt(8'd2, 0, 1'b1, STATUS_OK, 32'hDEAD_0002, 2));
      offer(pkt(8'd2, 7, 1'b1, STATUS_OK, 32'hBEEF_0002, 514));       // duplicate overwrites
      offer(pkt(8'd1, 256, 1'b1, STATUS_OK, 32'h8000_0001, 512));     // drains 1..3
      offer(pkt(8'd255, 9, 1'b1, STATUS_OK, 32'h5555_AAAA, 3));       // behind window: resend
      offer(pkt(8'd200, 0, 1'b1, STATUS_TRUNC, 32'hAAAA_5555, 4));    // halve window, nack
      offer(pkt(8'd0, 9, 1'b1, STATUS_OK, 32'h0F0F_F0F0, 8));         // resend of the nack
      offer(pkt(8'd19, 33, 1'b1, STATUS_OK, 32'h7777_0019, 19));      // top of window
      offer(pkt(8'd20, 34, 1'b1, STATUS_OK, 32'h7777_0020, 20));      // just past it
      offer(pkt(8'd4, 44, 1'b1, STATUS_OK, 32'h7777_0004, 40));
      offer(pkt(8'd5, 100, 1'b1, STATUS_TRUNC, 32'h7777_0005, 41));
      settle();

      for (int ph = 0; ph < 6; ph++) begin
         set_max_window(ph == 5 ? 5'($urandom_range(1, 31)) : window_plan[ph]);
         no_idle = (ph == 3);
         phase_end = items_queued + PHASE_ITEMS;
         while (items_queued < phase_end) begin
            queue_burst();
            wait_sent();
         end
         settle();
      end
      no_idle = 1'b0;

      // close the stream whatever the window is, then show later headers are dropped
      e = next_seq;
      offer(pkt(e + 8'd1, 0, 1'b1, STATUS_OK, $urandom, $urandom_range(0, 1023)));
      offer(pkt(e, 40, 1'b1, STATUS_OK, $urandom, $urandom_range(0, 1023)));
      offer(pkt(e + 8'd1, 0, 1'b1, STATUS_OK, $urandom, $urandom_range(0, 1023)));
      offer(pkt(e + 8'd2, 12, 1'b1, STATUS_OK, $urandom, $urandom_range(0, 1023)));
      offer(pkt(e, 12, 1'b1, STATUS_TRUNC, $urandom, $urandom_range(0, 1023)));
      settle();

      if (due_results.size() != 0)
         flag_error("beats never seen, count", 32'(due_results.size()), 32'd0);
      if (error_count == 0) begin
         $display("selective_repeat_receive_window verification clean");
      end else begin
         $display("selective_repeat_receive_window verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
design/srrw_pkg.sv
design/srrw_slot_ram.sv
design/srrw_ctrl.sv
design/selective_repeat_receive_window.sv
design/srrw_checker.sv
tb/sv/tb.sv
